[rtl/core/shp_pkg.sv]
// shared types, codes and constants of the stepper homing positioner
`default_nettype none

package shp_pkg;

  // default motor resolution, steps per half turn is half of it
  localparam int unsigned STEPS_PER_TURN_DEF = 2048;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [15:0] LIMIT_WAIT_RST  = 16'd50;
  localparam logic [9:0]  EDGE_SEARCH_RST = 10'd42;
  localparam logic [9:0]  DEEP_OFFSET_RST = 10'd42;

  // register indexes
  typedef enum logic [1:0] {
    REG_LIMIT_WAIT  = 2'd0,
    REG_EDGE_SEARCH = 2'd1,
    REG_DEEP_OFFSET = 2'd2
  } reg_idx_t;

  // func codes of an input item
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_MOVE  = 2'd1;
  localparam logic [1:0] FUNC_HOME  = 2'd2;
  // unused code, taken as a plain tick
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // kind of request carried or pending
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_HOME = 2'd2
  } kind_t;

  // job phase
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_LEFT  = 4'd1,
    PH_WAIT  = 4'd2,
    PH_SEEK  = 4'd3,
    PH_BACK  = 4'd4,
    PH_APPR  = 4'd5,
    PH_APPR2 = 4'd6,
    PH_DEEP  = 4'd7,
    PH_MOVE  = 4'd8
  } phase_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] target_steps;
    logic               left_limit_level;
    logic               right_limit_level;
    logic               home_level;
  } in_item_t;

  typedef struct packed {
    logic               step_pulse;
    logic               step_toward_left;
    logic               motor_enable;
    logic               busy_res;
    logic               calibrated;
    logic               homing_failed;
    logic signed [15:0] position_steps;
  } out_item_t;

  // classified tick handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] target;
    logic               left_hit;
    logic               right_hit;
    logic               home_on;
  } cmd_t;

  // configuration seen by the tick engine
  typedef struct packed {
    logic [15:0] limit_wait;
    logic [9:0]  edge_search;
    logic [9:0]  deep_offset;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/stepper_homing_positioner.sv]
// top level of the stepper homing positioner: register port and front/back wiring
`default_nettype none

// Each input item is one tick: it samples the two limit switches and the home
// sensor, may carry a move target or a home request, and yields exactly one
// result item with the step command, status flags and position. The block
// takes one item per clock while its input queue is not full; results wait
// in its two-entry output queue. An item is registered in the input queue and
// its result in the output queue. The tick engine resolves every phase change
// of a tick, including a homing run that hands over to a move, combinationally.
// Homing runs after reset. Registers: limit wait ticks at 0x0, edge search
// steps at 0x4, deep offset steps at 0x8; write them only while the block is idle.
module stepper_homing_positioner #(
  parameter int unsigned STEPS_PER_TURN = shp_pkg::STEPS_PER_TURN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  output logic                                 full,
  input  wire shp_pkg::in_item_t               in_item,
  output logic                                 empty,
  input  wire logic                            pop,
  output shp_pkg::out_item_t                   out_item,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [shp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [shp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [shp_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import shp_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_sel;
  logic     cfg_we;
  logic     cmd_valid, cmd_ready;
  cmd_t     cmd;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_wait  <= LIMIT_WAIT_RST;
      cfg_r.edge_search <= EDGE_SEARCH_RST;
      cfg_r.deep_offset <= DEEP_OFFSET_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_LIMIT_WAIT:  cfg_r.limit_wait  <= pwdata[15:0];
        REG_EDGE_SEARCH: cfg_r.edge_search <= pwdata[9:0];
        REG_DEEP_OFFSET: cfg_r.deep_offset <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_sel)
      REG_LIMIT_WAIT:  prdata = {16'd0, cfg_r.limit_wait};
      REG_EDGE_SEARCH: prdata = {22'd0, cfg_r.edge_search};
      REG_DEEP_OFFSET: prdata = {22'd0, cfg_r.deep_offset};
      default:         prdata = '0;
    endcase
  end

  shp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  shp_back #(
    .STEPS_PER_TURN (STEPS_PER_TURN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[rtl/core/shp_front.sv]
// front end: accepts items, classifies them and queues them for the tick engine
`default_nettype none

module shp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire shp_pkg::in_item_t in_item,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output shp_pkg::cmd_t         cmd
);
  import shp_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cls;
  logic       wr_en, rd_en;

  // decode func and turn the raw sensor levels into active-high flags
  always_comb begin
    cls.target    = in_item.target_steps;
    cls.left_hit  = ~in_item.left_limit_level;
    cls.right_hit = ~in_item.right_limit_level;
    cls.home_on   = in_item.home_level;
    case (in_item.func)
      FUNC_MOVE: cls.kind = KIND_MOVE;
      FUNC_HOME: cls.kind = KIND_HOME;
      default:   cls.kind = KIND_NONE;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign wr_en     = push && !full;
  assign rd_en     = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= cls;
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/shp_back.sv]
// back end: tick engine for homing and moves, with the result queue
`default_nettype none

module shp_back #(
  parameter int unsigned STEPS_PER_TURN = shp_pkg::STEPS_PER_TURN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire shp_pkg::cfg_t     cfg,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire shp_pkg::cmd_t     cmd,
  output logic                   empty,
  input  wire logic              pop,
  output shp_pkg::out_item_t     out_item
);
  import shp_pkg::*;

  // half range limits, both saturating at the ends of the 16 bit position range
  localparam int HALF = int'(STEPS_PER_TURN / 2);
  localparam int HI_I = (HALF > 32767) ? 32767 : HALF;
  localparam int LO_I = -((HALF > 32768) ? 32768 : HALF);
  localparam logic signed [15:0] HALF_HI = 16'(HI_I);
  localparam logic signed [15:0] HALF_LO = 16'(LO_I);
  // upper bound on the chain of homing phases evaluated in one tick
  localparam int HOME_EVALS = 6;

  phase_t             phase_r, phase_nxt;
  logic signed [15:0] position_r, position_nxt;
  logic               is_cal_r, is_cal_nxt;
  logic signed [15:0] move_target_r, move_target_nxt;
  kind_t              pending_kind_r, pending_kind_nxt;
  logic signed [15:0] pending_target_r, pending_target_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic               fail_r, fail_nxt;
  logic               then_move_r, then_move_nxt;

  out_item_t          oq_r [2];
  logic               owp_r, orp_r;
  logic [1:0]         ocnt_r;

  logic               take, opop;
  out_item_t          res;

  logic               cnt_lt_w, cnt_lt_e, cnt_lt_d;
  logic               wait_nz, edge_nz, deep_nz;

  logic               clr, inc, stepped, to_left, ended, go_move, zero_pos;
  logic               finish, finish_ok, lt_w, lt_e, lt_d;
  logic signed [15:0] p;

  assign cmd_ready = (ocnt_r != 2'd2);
  assign take      = cmd_valid && cmd_ready;
  assign empty     = (ocnt_r == 2'd0);
  assign opop      = pop && !empty;
  assign out_item  = oq_r[orp_r];

  // counter compares against the stored count and against a fresh zero
  assign cnt_lt_w = cnt_r < cfg.limit_wait;
  assign cnt_lt_e = cnt_r < {6'd0, cfg.edge_search};
  assign cnt_lt_d = cnt_r < {6'd0, cfg.deep_offset};
  assign wait_nz  = (cfg.limit_wait != 16'd0);
  assign edge_nz  = (cfg.edge_search != 10'd0);
  assign deep_nz  = (cfg.deep_offset != 10'd0);

  // one tick: latch request, start a job, walk homing phases, then move
  always_comb begin
    pending_kind_nxt   = pending_kind_r;
    pending_target_nxt = pending_target_r;
    phase_nxt          = phase_r;
    move_target_nxt    = move_target_r;
    is_cal_nxt         = is_cal_r;
    fail_nxt           = fail_r;
    then_move_nxt      = then_move_r;
    clr = 1'b0; inc = 1'b0; stepped = 1'b0; to_left = 1'b0;
    ended = 1'b0; go_move = 1'b0; zero_pos = 1'b0;
    finish = 1'b0; finish_ok = 1'b0;
    lt_w = 1'b0; lt_e = 1'b0; lt_d = 1'b0;

    // latest request wins
    case (cmd.kind)
      KIND_MOVE: begin
        pending_kind_nxt   = KIND_MOVE;
        pending_target_nxt = cmd.target;
      end
      KIND_HOME: pending_kind_nxt = KIND_HOME;
      default: ;
    endcase

    // start a pending job when idle
    if (phase_r == PH_IDLE && pending_kind_nxt != KIND_NONE) begin
      if (pending_kind_nxt == KIND_HOME) begin
        phase_nxt     = PH_LEFT;
        clr           = 1'b1;
        fail_nxt      = 1'b0;
        then_move_nxt = 1'b0;
      end else begin
        if (pending_target_nxt > HALF_HI) begin
          move_target_nxt = HALF_HI;
        end else if (pending_target_nxt < HALF_LO) begin
          move_target_nxt = HALF_LO;
        end else begin
          move_target_nxt = pending_target_nxt;
        end
        if (!is_cal_r) begin
          phase_nxt     = PH_LEFT;
          clr           = 1'b1;
          fail_nxt      = 1'b0;
          then_move_nxt = 1'b1;
        end else begin
          phase_nxt = PH_MOVE;
        end
      end
      pending_kind_nxt = KIND_NONE;
    end

    // homing phases that fall through without a step
    for (int i = 0; i < HOME_EVALS; i++) begin
      if (!(stepped || ended || go_move)) begin
        finish    = 1'b0;
        finish_ok = 1'b0;
        lt_w = clr ? wait_nz : cnt_lt_w;
        lt_e = clr ? edge_nz : cnt_lt_e;
        lt_d = clr ? deep_nz : cnt_lt_d;
        case (phase_nxt)
          PH_LEFT: begin
            if (cmd.left_hit) begin
              phase_nxt = PH_WAIT; clr = 1'b1;
            end else begin
              stepped = 1'b1; to_left = 1'b1;
            end
          end
          PH_WAIT: begin
            if (lt_w) begin
              inc = 1'b1; ended = 1'b1;
            end else begin
              phase_nxt = PH_SEEK; clr = 1'b1;
            end
          end
          PH_SEEK: begin
            if (cmd.home_on) begin
              phase_nxt = PH_BACK; clr = 1'b1;
            end else if (cmd.right_hit) begin
              fail_nxt = 1'b1; finish = 1'b1;
            end else begin
              stepped = 1'b1; to_left = 1'b0;
            end
          end
          PH_BACK: begin
            if (cmd.home_on && lt_e) begin
              inc = 1'b1; stepped = 1'b1; to_left = 1'b1;
            end else begin
              phase_nxt = PH_APPR; clr = 1'b1;
            end
          end
          PH_APPR: begin
            if (!cmd.home_on && lt_e) begin
              inc = 1'b1; stepped = 1'b1; to_left = 1'b0;
            end else if (cmd.home_on) begin
              phase_nxt = PH_APPR2; clr = 1'b1; stepped = 1'b1; to_left = 1'b1;
            end else begin
              finish = 1'b1; finish_ok = 1'b1;
            end
          end
          PH_APPR2: begin
            if (!cmd.home_on && lt_e) begin
              inc = 1'b1; stepped = 1'b1; to_left = 1'b0;
            end else if (cmd.home_on) begin
              phase_nxt = PH_DEEP; clr = 1'b1;
            end else begin
              finish = 1'b1; finish_ok = 1'b1;
            end
          end
          PH_DEEP: begin
            if (cmd.home_on && lt_d) begin
              inc = 1'b1; stepped = 1'b1; to_left = 1'b0;
            end else begin
              finish = 1'b1; finish_ok = 1'b1;
            end
          end
          PH_MOVE: go_move = 1'b1;
          default: begin
            phase_nxt = PH_IDLE; ended = 1'b1;
          end
        endcase
        // end of a homing run, possibly carrying on into the move
        if (finish) begin
          if (finish_ok || then_move_nxt) begin
            zero_pos   = 1'b1;
            is_cal_nxt = 1'b1;
          end
          clr = 1'b1;
          if (then_move_nxt) begin
            then_move_nxt = 1'b0;
            phase_nxt     = PH_MOVE;
            go_move       = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
            ended     = 1'b1;
          end
        end
      end
    end

    // move: one step toward the target, stopping on a limit
    p            = zero_pos ? 16'sd0 : position_r;
    position_nxt = p;
    if (go_move) begin
      if (p < move_target_nxt) begin
        if (cmd.right_hit) begin
          position_nxt = HALF_HI; phase_nxt = PH_IDLE;
        end else begin
          position_nxt = p + 16'sd1; stepped = 1'b1; to_left = 1'b0;
        end
      end else if (p > move_target_nxt) begin
        if (cmd.left_hit) begin
          position_nxt = HALF_LO; phase_nxt = PH_IDLE;
        end else begin
          position_nxt = p - 16'sd1; stepped = 1'b1; to_left = 1'b1;
        end
      end else begin
        phase_nxt = PH_IDLE;
      end
    end

    // phase counter
    if (inc) begin
      cnt_nxt = clr ? 16'd1 : cnt_r + 16'd1;
    end else begin
      cnt_nxt = clr ? 16'd0 : cnt_r;
    end

    // result item
    res.step_pulse       = stepped;
    res.step_toward_left = stepped && to_left;
    res.motor_enable     = (phase_nxt != PH_IDLE);
    res.busy_res         = (phase_nxt != PH_IDLE);
    res.calibrated       = is_cal_nxt;
    res.homing_failed    = fail_nxt;
    res.position_steps   = position_nxt;
  end

  // engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_LEFT;
      position_r       <= 16'sd0;
      is_cal_r         <= 1'b0;
      move_target_r    <= 16'sd0;
      pending_kind_r   <= KIND_NONE;
      pending_target_r <= 16'sd0;
      cnt_r            <= 16'd0;
      fail_r           <= 1'b0;
      then_move_r      <= 1'b0;
    end else if (take) begin
      phase_r          <= phase_nxt;
      position_r       <= position_nxt;
      is_cal_r         <= is_cal_nxt;
      move_target_r    <= move_target_nxt;
      pending_kind_r   <= pending_kind_nxt;
      pending_target_r <= pending_target_nxt;
      cnt_r            <= cnt_nxt;
      fail_r           <= fail_nxt;
      then_move_r      <= then_move_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (take) begin
      oq_r[owp_r] <= res;
    end
  end

  // result queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (take) owp_r <= ~owp_r;
      if (opop) orp_r <= ~orp_r;
      case ({take, opop})
        2'b10:   ocnt_r <= ocnt_r + 2'd1;
        2'b01:   ocnt_r <= ocnt_r - 2'd1;
        default: ocnt_r <= ocnt_r;
      endcase
    end
  end

  // a stepping tick never ends a job
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.step_pulse |-> res.busy_res)
    else $error("step issued on a finishing tick");

  // calibration is never lost
  a_cal_hold: assert property (@(posedge clk) disable iff (!rst_n)
    is_cal_r |=> is_cal_r)
    else $error("calibrated flag dropped");

  // a tick that finds the block idle leaves nothing pending
  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_IDLE |=> pending_kind_r == KIND_NONE)
    else $error("request left pending while idle");

  // result queue never overfills
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r != 2'd3)
    else $error("result queue overflow");

endmodule

`default_nettype wire

[dv/shp_checker.sv]
// item checker for the stepper homing positioner: tick predictor and result compare
`default_nettype none

module shp_checker
  import shp_pkg::*;
#(
  parameter int unsigned STEPS_PER_TURN = STEPS_PER_TURN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic                  full,
  input  wire in_item_t              in_item,
  input  wire logic                  empty,
  input  wire logic                  pop,
  input  wire out_item_t             out_item,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output int                         mismatches,
  output int                         results_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  // half range bounds, both saturate at the ends of the 16 bit range
  localparam int unsigned HALF_TURN = STEPS_PER_TURN / 2;
  localparam logic signed [15:0] HALF_HI = (HALF_TURN > 32767) ? 16'h7FFF : 16'(HALF_TURN);
  localparam logic signed [15:0] HALF_LO =
    (HALF_TURN >= 32768) ? 16'h8000 : 16'(-int'(HALF_TURN));

  // register copies, kept in step with writes seen on the register port
  logic [15:0] wait_ticks;
  logic [9:0]  search_steps;
  logic [9:0]  deep_steps;

  // shadow of the positioner state
  phase_t             axis_phase;
  logic signed [15:0] pos_steps;
  logic               homed;
  logic signed [15:0] move_goal;
  kind_t              queued_kind;
  logic signed [15:0] queued_goal;
  logic [15:0]        phase_cnt;
  logic               home_missed;
  logic               move_after_home;

  out_item_t expected_q[$];
  out_item_t want;
  int        results_seen;

  // close a homing run; returns 1 when the same tick carries on into the move
  function automatic logic finish_homing(input logic ok);
    if (ok || move_after_home) begin
      pos_steps = '0;
      homed = 1'b1;
    end
    phase_cnt = '0;
    if (move_after_home) begin
      move_after_home = 1'b0;
      axis_phase = PH_MOVE;
      return 1'b1;
    end
    axis_phase = PH_IDLE;
    return 1'b0;
  endfunction

  // advance the shadow by one tick and return the result item it gives
  function automatic out_item_t next_tick(input in_item_t it);
    logic               left_hit;
    logic               right_hit;
    logic               home_on;
    logic               stepped;
    logic               to_left;
    logic               ended;
    logic signed [15:0] goal;
    kind_t              kind;
    out_item_t          res;
    int                 n;
    left_hit  = !it.left_limit_level;
    right_hit = !it.right_limit_level;
    home_on   = it.home_level;
    stepped   = 1'b0;
    to_left   = 1'b0;
    ended     = 1'b0;

    // latch the request, the latest one wins
    if (it.func == FUNC_MOVE) begin
      queued_kind = KIND_MOVE;
      queued_goal = it.target_steps;
    end else if (it.func == FUNC_HOME) begin
      queued_kind = KIND_HOME;
    end

    // start a waiting request once idle
    if (axis_phase == PH_IDLE && queued_kind != KIND_NONE) begin
      kind = queued_kind;
      queued_kind = KIND_NONE;
      if (kind == KIND_HOME) begin
        axis_phase = PH_LEFT;
        phase_cnt = '0;
        home_missed = 1'b0;
        move_after_home = 1'b0;
      end else begin
        goal = queued_goal;
        if (goal > HALF_HI) goal = HALF_HI;
        if (goal < HALF_LO) goal = HALF_LO;
        move_goal = goal;
        if (!homed) begin
          axis_phase = PH_LEFT;
          phase_cnt = '0;
          home_missed = 1'b0;
          move_after_home = 1'b1;
        end else begin
          axis_phase = PH_MOVE;
        end
      end
    end

    // resolve phase changes until a step is issued or the tick ends
    for (n = 0; n < 16 && !stepped && !ended; n++) begin
      case (axis_phase)
        PH_LEFT: begin
          if (left_hit) begin
            axis_phase = PH_WAIT;
            phase_cnt = '0;
          end else begin
            stepped = 1'b1;
            to_left = 1'b1;
          end
        end
        PH_WAIT: begin
          if (phase_cnt < wait_ticks) begin
            phase_cnt++;
            ended = 1'b1;
          end else begin
            axis_phase = PH_SEEK;
            phase_cnt = '0;
          end
        end
        PH_SEEK: begin
          if (home_on) begin
            axis_phase = PH_BACK;
            phase_cnt = '0;
          end else if (right_hit) begin
            home_missed = 1'b1;
            ended = !finish_homing(1'b0);
          end else begin
            stepped = 1'b1;
            to_left = 1'b0;
          end
        end
        PH_BACK: begin
          if (home_on && phase_cnt < search_steps) begin
            phase_cnt++;
            stepped = 1'b1;
            to_left = 1'b1;
          end else begin
            axis_phase = PH_APPR;
            phase_cnt = '0;
          end
        end
        PH_APPR: begin
          if (!home_on && phase_cnt < search_steps) begin
            phase_cnt++;
            stepped = 1'b1;
            to_left = 1'b0;
          end else if (home_on) begin
            axis_phase = PH_APPR2;
            phase_cnt = '0;
            stepped = 1'b1;
            to_left = 1'b1;
          end else begin
            ended = !finish_homing(1'b1);
          end
        end
        PH_APPR2: begin
          if (!home_on && phase_cnt < search_steps) begin
            phase_cnt++;
            stepped = 1'b1;
            to_left = 1'b0;
          end else if (home_on) begin
            axis_phase = PH_DEEP;
            phase_cnt = '0;
          end else begin
            ended = !finish_homing(1'b1);
          end
        end
        PH_DEEP: begin
          if (home_on && phase_cnt < deep_steps) begin
            phase_cnt++;
            stepped = 1'b1;
            to_left = 1'b0;
          end else begin
            ended = !finish_homing(1'b1);
          end
        end
        PH_MOVE: begin
          if (pos_steps < move_goal) begin
            if (right_hit) begin
              pos_steps = HALF_HI;
              axis_phase = PH_IDLE;
              ended = 1'b1;
            end else begin
              pos_steps++;
              stepped = 1'b1;
              to_left = 1'b0;
            end
          end else if (pos_steps > move_goal) begin
            if (left_hit) begin
              pos_steps = HALF_LO;
              axis_phase = PH_IDLE;
              ended = 1'b1;
            end else begin
              pos_steps--;
              stepped = 1'b1;
              to_left = 1'b1;
            end
          end else begin
            axis_phase = PH_IDLE;
            ended = 1'b1;
          end
        end
        default: begin
          axis_phase = PH_IDLE;
          ended = 1'b1;
        end
      endcase
    end

    res.step_pulse       = stepped;
    res.step_toward_left = stepped && to_left;
    res.motor_enable     = (axis_phase != PH_IDLE);
    res.busy_res         = (axis_phase != PH_IDLE);
    res.calibrated       = homed;
    res.homing_failed    = home_missed;
    res.position_steps   = pos_steps;
    return res;
  endfunction

  // one field of one result item
  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, exp_val, got_val);
    end
  endtask

  // watch register writes, items in and items out
  always @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks      = LIMIT_WAIT_RST;
      search_steps    = EDGE_SEARCH_RST;
      deep_steps      = DEEP_OFFSET_RST;
      axis_phase      = PH_LEFT;
      pos_steps       = '0;
      homed           = 1'b0;
      move_goal       = '0;
      queued_kind     = KIND_NONE;
      queued_goal     = '0;
      phase_cnt       = '0;
      home_missed     = 1'b0;
      move_after_home = 1'b0;
      expected_q.delete();
      results_seen    = 0;
      mismatches      = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LIMIT_WAIT:  wait_ticks   = pwdata[15:0];
          REG_EDGE_SEARCH: search_steps = pwdata[9:0];
          REG_DEEP_OFFSET: deep_steps   = pwdata[9:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no item waiting for it", results_seen);
        end else begin
          want = expected_q.pop_front();
          check_field("step_pulse", int'(want.step_pulse), int'(out_item.step_pulse));
          check_field("step_toward_left", int'(want.step_toward_left),
                      int'(out_item.step_toward_left));
          check_field("motor_enable", int'(want.motor_enable), int'(out_item.motor_enable));
          check_field("busy_res", int'(want.busy_res), int'(out_item.busy_res));
          check_field("calibrated", int'(want.calibrated), int'(out_item.calibrated));
          check_field("homing_failed", int'(want.homing_failed),
                      int'(out_item.homing_failed));
          check_field("position_steps", int'(want.position_steps),
                      int'(out_item.position_steps));
        end
        results_seen++;
      end
      if (push && !full)
        expected_q.push_back(next_tick(in_item));
    end
    results_pending <= expected_q.size();
  end

endmodule

`default_nettype wire

[dv/tb_stepper_homing_positioner.sv]
// testbench top for the stepper homing positioner: axis stimulus, register setup, verdict
`default_nettype none

module tb_stepper_homing_positioner;

  timeunit 1ns;
  timeprecision 1ps;

  import shp_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic                  clk;
  logic                  rst_n   = 1'b0;
  logic                  push    = 1'b0;
  logic                  pop     = 1'b0;
  in_item_t              in_item = '0;
  out_item_t             out_item;
  logic                  full;
  logic                  empty;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int results_pending;

  // simple axis: position moved by the popped step items, switches fixed on it
  int axis_x   = 0;
  int lim_l    = -60;
  int lim_r    = 120;
  int home_lo  = 10;
  int home_hi  = 30;

  int send_idle_pct  = 15;
  int recv_idle_pct  = 57;
  int accepted_items = 0;
  int rand_index     = 0;
  int hold_left      = 0;
  logic hold_done    = 1'b0;
  int stall_cycles   = 0;

  stepper_homing_positioner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  shp_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_item         (in_item),
    .empty           (empty),
    .pop             (pop),
    .out_item        (out_item),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random pops, one long hold-off, axis follows the steps taken
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty && out_item.step_pulse)
        axis_x <= out_item.step_toward_left ? axis_x - 1 : axis_x + 1;
      if (!hold_done && accepted_items >= 650) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL stepper_homing_positioner");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // place new switches around the axis, optionally with no home sensor at all
  task automatic reshape_axis(input logic with_home);
    lim_l   = axis_x - int'($urandom_range(20, 180));
    home_lo = lim_l + int'($urandom_range(4, 60));
    home_hi = home_lo + int'($urandom_range(8, 40));
    lim_r   = home_hi + int'($urandom_range(8, 120));
    if (!with_home) begin
      home_lo = lim_r + 1000;
      home_hi = home_lo;
    end
  endtask

  // sensor levels from the axis, with some noise items
  function automatic in_item_t sample_axis();
    in_item_t it;
    it.func = FUNC_TICK;
    it.target_steps = 16'($urandom());
    if ($urandom_range(0, 99) < 6) begin
      it.left_limit_level  = 1'($urandom_range(0, 1));
      it.right_limit_level = 1'($urandom_range(0, 1));
      it.home_level        = 1'($urandom_range(0, 1));
    end else begin
      it.left_limit_level  = !(axis_x <= lim_l);
      it.right_limit_level = !(axis_x >= lim_r);
      it.home_level        = (axis_x >= home_lo) && (axis_x <= home_hi);
    end
    return it;
  endfunction

  // offer one item and hold it until taken, then maybe idle
  task automatic offer(input in_item_t it);
    in_item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    accepted_items <= accepted_items + 1;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic program_axis(input logic [15:0] lw, input logic [9:0] es, input logic [9:0] ds);
    write_reg(REG_LIMIT_WAIT, CFG_DATA_W'(lw));
    write_reg(REG_EDGE_SEARCH, CFG_DATA_W'(es));
    write_reg(REG_DEEP_OFFSET, CFG_DATA_W'(ds));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // random ticks with occasional moves and home requests
  task automatic random_ticks(input int count);
    in_item_t it;
    int       roll;
    for (int k = 0; k < count; k++) begin
      if (rand_index < 413) begin
        send_idle_pct = 15;
        recv_idle_pct <= 57;
      end else if (rand_index < 826) begin
        send_idle_pct = 57;
        recv_idle_pct <= 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) reshape_axis($urandom_range(0, 99) >= 25);
      it = sample_axis();
      if (roll < 2) begin
        it.func = FUNC_HOME;
      end else if (roll < 8) begin
        it.func = FUNC_MOVE;
        case ($urandom_range(0, 6))
          0: it.target_steps = 16'($urandom());
          1: it.target_steps = 16'(($urandom_range(0, 1) ? 1 : -1) *
                                   int'($urandom_range(1021, 1027)));
          default: it.target_steps = 16'(int'($urandom_range(0, 120)) - 60);
        endcase
      end else if (roll < 10) begin
        it.func = FUNC_SPARE;
      end
      offer(it);
      rand_index++;
    end
  endtask

  initial begin
    in_item_t it;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: startup homing, latched requests, unused code, switch extremes
    offer('{FUNC_TICK,  16'h0000, 1'b1, 1'b1, 1'b0});
    offer('{FUNC_SPARE, 16'h7FFF, 1'b1, 1'b1, 1'b1});
    offer('{FUNC_HOME,  16'h8000, 1'b1, 1'b1, 1'b0});
    offer('{FUNC_MOVE,  16'h8000, 1'b1, 1'b0, 1'b0});
    offer('{FUNC_MOVE,  16'h7FFF, 1'b1, 1'b1, 1'b1});
    offer('{FUNC_TICK,  16'hFFFF, 1'b0, 1'b0, 1'b1});
    offer('{FUNC_TICK,  16'h0001, 1'b0, 1'b0, 1'b0});
    offer('{FUNC_TICK,  16'h5555, 1'b1, 1'b0, 1'b1});
    offer('{FUNC_TICK,  16'hAAAA, 1'b0, 1'b1, 1'b0});
    offer('{FUNC_SPARE, 16'h0000, 1'b1, 1'b1, 1'b1});

    // reset settings
    reshape_axis(1'b1);
    random_ticks(300);
    drain();

    // lowest settings, searches take no steps
    program_axis(16'd0, 10'd0, 10'd0);
    random_ticks(250);
    drain();

    // highest settings, homing parks in the long pause
    program_axis(16'hFFFF, 10'h3FF, 10'h3FF);
    reshape_axis(1'b1);
    it = sample_axis();
    it.func = FUNC_HOME;
    offer(it);
    random_ticks(120);
    drain();

    // short pause with the widest searches
    program_axis(16'd1, 10'h3FF, 10'h3FF);
    random_ticks(250);
    drain();

    // mid-range settings
    program_axis(16'($urandom_range(0, 20)), 10'($urandom_range(1, 60)),
                 10'($urandom_range(0, 60)));
    random_ticks(320);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS stepper_homing_positioner");
    end else begin
      $display("FAIL stepper_homing_positioner");
    end
    $finish;
  end

endmodule

`default_nettype wire
